>>> sv/ecob_pkg.sv
// Package with constants and payload types for the element center box test.
`default_nettype none
package ecob_pkg;

  localparam int MAX_BOXES     = 16;
  localparam int COORD_WIDTH   = 32;
  localparam int WORDS_PER_BOX = 15;
  localparam int TABLE_DEPTH   = MAX_BOXES * WORDS_PER_BOX;
  localparam int ADDR_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int BOX_LIMIT     = (MAX_BOXES < 16) ? MAX_BOXES : 16;
  localparam int COORD_EFF     = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

  localparam logic [4:0] NO_HIT     = 5'd16;
  localparam logic       FUNC_LOAD  = 1'b0;
  localparam logic       FUNC_NODE  = 1'b1;
  localparam logic [3:0] WORD_OFFS  = 4'd9;
  localparam logic [3:0] WORD_EXTS  = 4'd12;
  localparam logic [3:0] WORD_NONE  = 4'd15;

  typedef struct packed {
    logic               func;
    logic [3:0]         box_index;
    logic [3:0]         word_index;
    logic signed [31:0] word_value;
    logic signed [31:0] node_x;
    logic signed [31:0] node_y;
    logic signed [31:0] node_z;
    logic               last_node;
  } req_t;

  typedef struct packed {
    logic       refine;
    logic [4:0] hit_box;
  } rsp_t;

endpackage
`default_nettype wire

>>> sv/element_center_in_oriented_boxes.sv
// Top level: element bounding-box center tested against a table of oriented boxes.
// Table loads and non-final nodes are taken while idle and give no result.
// A final node starts a walk over at most box_count boxes (capped at 16), reading five table words per axis examined;
// each table word passes the one shared multiplier/adder through the states S_RD, S_MUL and S_ACC.
// No new transaction is taken while the box walk runs.
// Reset (synchronous) clears the control state and box_count; the box table is
// undefined until written.
`default_nettype none
module element_center_in_oriented_boxes (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic [4:0]     cfg_wdata,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire ecob_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output ecob_pkg::rsp_t      rsp
);

  typedef enum logic [2:0] {
    S_IDLE, S_CTR, S_RD, S_MUL, S_ACC, S_DONE
  } state_t;

  localparam int AW = ecob_pkg::ADDR_W;
  localparam int SH = 32 - ecob_pkg::COORD_EFF;

  state_t state;
  logic [4:0] box_count;
  logic first_pending;
  logic signed [31:0] elem_min [3];
  logic signed [31:0] elem_max [3];
  logic signed [31:0] ctr [3];
  logic signed [31:0] box_table [ecob_pkg::TABLE_DEPTH];
  logic signed [31:0] rdata;
  logic signed [63:0] acc;
  logic signed [63:0] prod;
  logic [4:0] box;
  logic [AW-1:0] base;
  logic [1:0] axis;
  logic [2:0] k;
  logic [4:0] hit;

  logic signed [31:0] pt [3];
  logic signed [31:0] min_next [3];
  logic signed [31:0] max_next [3];
  logic [4:0] n_eff;
  logic [3:0] wsel;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic signed [31:0] csel;
  logic signed [63:0] mul_res;
  logic signed [63:0] sum_res;
  logic signed [63:0] abs_res;
  logic signed [64:0] sum_wide;
  logic req_acc;
  logic load_ok;

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;

  assign pt[0] = ($signed(req.node_x) <<< SH) >>> SH;
  assign pt[1] = ($signed(req.node_y) <<< SH) >>> SH;
  assign pt[2] = ($signed(req.node_z) <<< SH) >>> SH;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (first_pending) begin
        min_next[a] = pt[a];
        max_next[a] = pt[a];
      end else begin
        min_next[a] = (pt[a] < elem_min[a]) ? pt[a] : elem_min[a];
        max_next[a] = (pt[a] > elem_max[a]) ? pt[a] : elem_max[a];
      end
    end
  end

  assign n_eff = (box_count > 5'(ecob_pkg::BOX_LIMIT)) ? 5'(ecob_pkg::BOX_LIMIT) : box_count;

  always_comb begin
    if (k == 3'd3) begin
      wsel = ecob_pkg::WORD_OFFS + 4'(axis);
    end else if (k == 3'd4) begin
      wsel = ecob_pkg::WORD_EXTS + 4'(axis);
    end else begin
      wsel = 4'(axis) * 4'd3 + 4'(k);
    end
  end

  assign raddr = base + AW'(wsel);
  assign waddr = AW'(32'(req.box_index) * ecob_pkg::WORDS_PER_BOX + 32'(req.word_index));
  assign load_ok = req_acc && (req.func == ecob_pkg::FUNC_LOAD)
                   && (req.word_index != ecob_pkg::WORD_NONE)
                   && (32'(req.box_index) < ecob_pkg::MAX_BOXES);

  assign csel = (k == 3'd0) ? ctr[0] : (k == 3'd1) ? ctr[1] : ctr[2];
  assign mul_res = rdata * csel;

  assign sum_wide = {acc[63], acc} + {prod[63], prod};
  always_comb begin
    if (sum_wide[64] != sum_wide[63]) begin
      sum_res = sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sum_res = sum_wide[63:0];
    end
  end

  always_comb begin
    if (acc == {1'b1, 63'd0}) begin
      abs_res = {1'b0, {63{1'b1}}};
    end else begin
      abs_res = acc[63] ? -acc : acc;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      box_table[waddr] <= req.word_value;
    end
    if (state == S_RD) begin
      rdata <= box_table[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      box_count <= 5'd0;
      first_pending <= 1'b1;
      rsp_valid <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        elem_min[a] <= 32'sd0;
        elem_max[a] <= 32'sd0;
      end
    end else begin
      if (cfg_we) begin
        box_count <= cfg_wdata;
      end
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_acc && req.func == ecob_pkg::FUNC_NODE) begin
            elem_min <= min_next;
            elem_max <= max_next;
            first_pending <= req.last_node;
            if (req.last_node) begin
              state <= S_CTR;
            end
          end
        end
        S_CTR: begin
          for (int a = 0; a < 3; a++) begin
            ctr[a] <= 32'(({elem_min[a][31], elem_min[a]} + {elem_max[a][31], elem_max[a]}) >>> 1);
          end
          box <= 5'd0;
          base <= '0;
          axis <= 2'd0;
          k <= 3'd0;
          acc <= 64'sd0;
          hit <= ecob_pkg::NO_HIT;
          state <= (n_eff == 5'd0) ? S_DONE : S_RD;
        end
        S_RD: begin
          state <= S_MUL;
        end
        S_MUL: begin
          if (k == 3'd3) begin
            prod <= -(64'(rdata) <<< 16);
          end else if (k == 3'd4) begin
            prod <= 64'(rdata) <<< 15;
            acc <= abs_res;
          end else begin
            prod <= mul_res;
          end
          state <= S_ACC;
        end
        S_ACC: begin
          if (k != 3'd4) begin
            acc <= sum_res;
            k <= k + 3'd1;
            state <= S_RD;
          end else if (acc > prod) begin
            box <= box + 5'd1;
            base <= base + AW'(ecob_pkg::WORDS_PER_BOX);
            axis <= 2'd0;
            k <= 3'd0;
            acc <= 64'sd0;
            state <= (box + 5'd1 == n_eff) ? S_DONE : S_RD;
          end else if (axis == 2'd2) begin
            hit <= box;
            state <= S_DONE;
          end else begin
            axis <= axis + 2'd1;
            k <= 3'd0;
            acc <= 64'sd0;
            state <= S_RD;
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            rsp.refine <= (hit != ecob_pkg::NO_HIT);
            rsp.hit_box <= hit;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_rsp_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.refine == (rsp.hit_box != ecob_pkg::NO_HIT)))
    else $error("refine and hit_box disagree");
  a_box_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> (box < n_eff)) else $error("box walk past box_count");
  a_abs_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC && k == 3'd4) |-> !acc[63]) else $error("absolute value negative");
  a_last_walk: assert property (@(posedge clk) disable iff (rst)
    (req_acc && req.func == ecob_pkg::FUNC_NODE && req.last_node) |=> (state == S_CTR))
    else $error("final node did not start the walk");

endmodule
`default_nettype wire

>>> bench/element_center_in_oriented_boxes_tb.sv
// Testbench for the element center box test: directed table, random elements, checked by a predictor.
`timescale 1ns / 100ps
`default_nettype none
module element_center_in_oriented_boxes_tb;

  localparam int LONG_WAIT = 20000;
  localparam int TAIL_WAIT = 3 + 45 * 16 + 20;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  typedef struct {
    logic                is_cfg;
    logic [4:0]          cfg_val;
    ecob_pkg::req_t      tr;
    logic                has_exp;
    ecob_pkg::rsp_t      exp_rsp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_wdata = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  ecob_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  ecob_pkg::rsp_t rsp;

  ecob_pkg::rsp_t expected_hits[$];
  ecob_pkg::rsp_t typed_hits[$];
  logic typed_flag[$];
  logic signed [63:0] boxes [0:ecob_pkg::TABLE_DEPTH-1];
  logic signed [63:0] lo_pt [0:2];
  logic signed [63:0] hi_pt [0:2];
  logic fresh_elem;
  logic [4:0] boxes_tested;
  int errors = 0;
  int idle_cycles = 0;
  logic hold_rx = 1'b0;
  logic burst_mode = 1'b0;

  element_center_in_oriented_boxes i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic signed [63:0] sadd(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic logic box_contains(int b, logic signed [63:0] c [0:2]);
    logic signed [63:0] dot;
    logic signed [63:0] mag;
    for (int a = 0; a < 3; a++) begin
      dot = 64'sd0;
      for (int k = 0; k < 3; k++) dot = sadd(dot, boxes[b*15 + a*3 + k] * c[k]);
      dot = sadd(dot, -(boxes[b*15 + 9 + a] * 64'sd65536));
      mag = (dot == 64'sh8000_0000_0000_0000) ? 64'sh7FFF_FFFF_FFFF_FFFF :
            (dot < 0 ? -dot : dot);
      if (mag > boxes[b*15 + 12 + a] * 64'sd32768) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict_center_test(input ecob_pkg::req_t t);
    logic signed [63:0] p [0:2];
    logic signed [63:0] c [0:2];
    logic signed [63:0] s;
    int n;
    ecob_pkg::rsp_t r;
    if (t.func == ecob_pkg::FUNC_LOAD) begin
      if (t.word_index != ecob_pkg::WORD_NONE && int'(t.box_index) < ecob_pkg::MAX_BOXES) begin
        boxes[t.box_index*15 + t.word_index] = 64'(t.word_value);
      end
      return;
    end
    p[0] = 64'(t.node_x); p[1] = 64'(t.node_y); p[2] = 64'(t.node_z);
    for (int a = 0; a < 3; a++) begin
      if (fresh_elem) begin
        lo_pt[a] = p[a]; hi_pt[a] = p[a];
      end else begin
        if (p[a] < lo_pt[a]) lo_pt[a] = p[a];
        if (p[a] > hi_pt[a]) hi_pt[a] = p[a];
      end
    end
    fresh_elem = 1'b0;
    if (!t.last_node) return;
    for (int a = 0; a < 3; a++) begin
      s = lo_pt[a] + hi_pt[a];
      c[a] = s >>> 1;
    end
    n = (int'(boxes_tested) > ecob_pkg::BOX_LIMIT) ? ecob_pkg::BOX_LIMIT : int'(boxes_tested);
    r.refine = 1'b0;
    r.hit_box = ecob_pkg::NO_HIT;
    for (int b = 0; b < n; b++) begin
      if (box_contains(b, c)) begin
        r.refine = 1'b1; r.hit_box = 5'(b); break;
      end
    end
    fresh_elem = 1'b1;
    expected_hits.push_back(r);
  endtask

  task automatic send(input ecob_pkg::req_t t, input logic has_exp = 1'b0,
                      input ecob_pkg::rsp_t typed = '0);
    if (burst_mode && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= t;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (t.func == ecob_pkg::FUNC_NODE && t.last_node) begin
      typed_flag.push_back(has_exp);
      typed_hits.push_back(typed);
    end
    predict_center_test(t);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  task automatic write_box_count(input logic [4:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    boxes_tested = v;
  endtask

  function automatic ecob_pkg::req_t load_word(int b, int w, logic signed [31:0] v);
    ecob_pkg::req_t t;
    t = '0;
    t.func = ecob_pkg::FUNC_LOAD; t.box_index = 4'(b); t.word_index = 4'(w);
    t.word_value = v;
    t.node_x = $urandom(); t.node_y = $urandom(); t.node_z = $urandom();
    t.last_node = 1'($urandom_range(0, 1));
    return t;
  endfunction

  function automatic ecob_pkg::req_t node(logic signed [31:0] x, logic signed [31:0] y,
                                          logic signed [31:0] z, logic last);
    ecob_pkg::req_t t;
    t.func = ecob_pkg::FUNC_NODE; t.box_index = 4'($urandom()); t.word_index = 4'($urandom());
    t.word_value = $urandom(); t.node_x = x; t.node_y = y; t.node_z = z;
    t.last_node = last;
    return t;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed(32'($urandom_range(0, 20 << 16))) - (10 <<< 16);
    endcase
  endfunction

  task automatic load_random_box(int b);
    int ax;
    logic signed [31:0] v;
    ax = $urandom_range(0, 2);
    for (int w = 0; w < 15; w++) begin
      if ($urandom_range(0, 7) == 0) v = $urandom();
      else if (w < 9) v = ($urandom_range(0, 3) == 0) ? $signed(32'($urandom_range(0, 2*ONE))) - ONE
                          : ((w % 3 == (w / 3 + ax) % 3) ? ONE : 32'sd0);
      else if (w < 12) v = $signed(32'($urandom_range(0, 10 << 16))) - (5 <<< 16);
      else v = ($urandom_range(0, 9) == 0) ? -ONE : 32'($urandom_range(0, 12 << 16));
      send(load_word(b, w, v));
    end
  endtask

  always @(posedge clk) begin
    if (rsp_valid && !rsp_stall) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected transaction refine=%0d hit_box=%0d", $time,
                 rsp.refine, rsp.hit_box);
        errors++;
      end else begin
        if (rsp.refine !== expected_hits[0].refine)
          $display("%0t: refine expected %0d actual %0d", $time,
                   expected_hits[0].refine, rsp.refine);
        if (rsp.hit_box !== expected_hits[0].hit_box)
          $display("%0t: hit_box expected %0d actual %0d", $time,
                   expected_hits[0].hit_box, rsp.hit_box);
        if (rsp !== expected_hits[0]) errors++;
        if (typed_flag.size() != 0) begin
          if (typed_flag[0] && typed_hits[0] !== rsp) begin
            $display("%0t: table entry expected %0d/%0d actual %0d/%0d", $time,
                     typed_hits[0].refine, typed_hits[0].hit_box, rsp.refine, rsp.hit_box);
            errors++;
          end
          void'(typed_flag.pop_front());
          void'(typed_hits.pop_front());
        end
        void'(expected_hits.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > LONG_WAIT + 50000) begin
      $display("element_center_in_oriented_boxes_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_rx) rsp_stall <= 1'b1;
    else case ($urandom_range(0, 2))
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 3) == 0);
      default: rsp_stall <= ($time / 2000) % 2 == 0 ? 1'b0 : ($urandom_range(0, 1) == 1);
    endcase
  end

  initial begin
    row_t rows [$];
    row_t r;
    ecob_pkg::rsp_t none_r;
    ecob_pkg::rsp_t hit0;
    int nel;
    int nb;
    none_r.refine = 1'b0; none_r.hit_box = ecob_pkg::NO_HIT;
    hit0.refine = 1'b1; hit0.hit_box = 5'd0;
    fresh_elem = 1'b1;
    boxes_tested = '0;
    for (int i = 0; i < ecob_pkg::TABLE_DEPTH; i++) begin
      boxes[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    r = '{is_cfg: 0, cfg_val: 0, tr: node(0, 0, 0, 1), has_exp: 1, exp_rsp: none_r};
    rows.push_back(r);
    r.tr = node(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    rows.push_back(r);
    for (int w = 0; w < 15; w++) begin
      r.tr = load_word(0, w, (w < 9) ? ((w % 4 == 0) ? ONE : 32'sd0)
                            : (w < 12 ? 32'sd0 : 32'sh4000_0000));
      r.has_exp = 0;
      rows.push_back(r);
    end
    r.tr = load_word(0, 15, 32'sh8000_0000); rows.push_back(r);
    r.is_cfg = 1; r.cfg_val = 5'd1; rows.push_back(r);
    r.is_cfg = 0; r.has_exp = 0; r.tr = node(ONE, -ONE, 0, 0); rows.push_back(r);
    r.has_exp = 1; r.exp_rsp = hit0; r.tr = node(-ONE, ONE, 32'sh0000_8000, 1);
    rows.push_back(r);
    r.has_exp = 0; r.tr = node(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1);
    rows.push_back(r);
    r.tr = load_word(0, 12, -ONE); rows.push_back(r);
    r.has_exp = 1; r.exp_rsp = none_r; r.tr = node(0, 0, 0, 1); rows.push_back(r);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain();
        write_box_count(rows[i].cfg_val);
      end else begin
        send(rows[i].tr, rows[i].has_exp, rows[i].exp_rsp);
      end
    end
    drain();
    write_box_count(5'd0);
    for (int b = 0; b < ecob_pkg::MAX_BOXES; b++) load_random_box(b);
    send(load_word(15, 15, $urandom()));

    burst_mode = 1'b1;
    nel = 0;
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: nb = 16;
        1: nb = 31;
        2: nb = 0;
        default: nb = $urandom_range(1, 16);
      endcase
      write_box_count(5'(nb));
      if (ph == 1) begin
        hold_rx = 1'b1;
        fork
          begin
            repeat (LONG_WAIT / 20) @(posedge clk);
            hold_rx = 1'b0;
          end
        join_none
      end
      for (int e = 0; e < 20; e++) begin
        int len;
        len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 6);
        if ($urandom_range(0, 9) == 0) load_random_box($urandom_range(0, 15));
        if ($urandom_range(0, 12) == 0) send(load_word($urandom_range(0, 15), 15, $urandom()));
        for (int k = 0; k < len; k++)
          send(node(rand_coord(), rand_coord(), rand_coord(), k == len - 1));
        nel++;
      end
    end
    drain();

    if (errors == 0) $display("element_center_in_oriented_boxes_tb: done, clean");
    else $display("element_center_in_oriented_boxes_tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
